// ----- rtl/ssra_pkg.sv -----
// ----------------------------------------------------------------------------
// ssra_pkg: shared types and microcode for the stable rank unit
// Item and result transaction formats, field widths and the control store.
// ----------------------------------------------------------------------------
package ssra_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 6;
    localparam int COUNT_W       = 7;
    localparam int STEP_W        = 3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   rank;
        logic [COUNT_W-1:0] item_count;
        logic               overflowed;
        logic               last_result;
    } result_t;

    // Read address source
    typedef enum logic [1:0] {
        ADDR_I,
        ADDR_J,
        ADDR_J_NEXT
    } addr_sel_t;

    // Jump condition: take target when true, else fall through to step + 1
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_CLOSE,
        COND_J_MORE,
        COND_I_MORE
    } cond_t;

    typedef struct packed {
        logic              busy;
        logic              emit;
        logic              clr_i;
        logic              inc_i;
        logic              clr_j;
        logic              ld_vi;
        logic              cmp;
        logic              clr_set;
        addr_sel_t         addr_sel;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctl_t;

    // Program step addresses
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_INIT  = 3'd1;
    localparam logic [STEP_W-1:0] ST_RDI   = 3'd2;
    localparam logic [STEP_W-1:0] ST_LATI  = 3'd3;
    localparam logic [STEP_W-1:0] ST_CMP   = 3'd4;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd5;
    localparam logic [STEP_W-1:0] ST_CLEAR = 3'd6;

    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t c;
        c = '{busy: 1'b1, emit: 1'b0, clr_i: 1'b0, inc_i: 1'b0, clr_j: 1'b0,
              ld_vi: 1'b0, cmp: 1'b0, clr_set: 1'b0, addr_sel: ADDR_I,
              cond: COND_NEVER, target: ST_IDLE};
        unique case (step)
            ST_IDLE:
            begin
                c.busy   = 1'b0;
                c.cond   = COND_NO_CLOSE;
                c.target = ST_IDLE;
            end
            ST_INIT:
            begin
                c.clr_i = 1'b1;
            end
            ST_RDI:
            begin
                c.addr_sel = ADDR_I;
                c.clr_j    = 1'b1;
            end
            ST_LATI:
            begin
                c.ld_vi    = 1'b1;
                c.addr_sel = ADDR_J;
            end
            ST_CMP:
            begin
                c.cmp      = 1'b1;
                c.addr_sel = ADDR_J_NEXT;
                c.cond     = COND_J_MORE;
                c.target   = ST_CMP;
            end
            ST_EMIT:
            begin
                c.emit   = 1'b1;
                c.inc_i  = 1'b1;
                c.cond   = COND_I_MORE;
                c.target = ST_RDI;
            end
            ST_CLEAR:
            begin
                c.clr_set = 1'b1;
                c.cond    = COND_ALWAYS;
                c.target  = ST_IDLE;
            end
            default:
            begin
                c.cond   = COND_ALWAYS;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/ssra_ram.sv -----
// ----------------------------------------------------------------------------
// ssra_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ssra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stable_sort_rank_assign.sv -----
// ----------------------------------------------------------------------------
// stable_sort_rank_assign: stable ascending rank of a loaded set
// Loads signed values, then emits each element's rank in load order.
// ----------------------------------------------------------------------------
// Transactions load while busy is low; busy stays low until the closing one.
// After the close, each element i is ranked in the steps RDI, LATI, CMP (n compares
// through the RAM read port) and EMIT; its result strobe is registered from EMIT.
// For a set of n elements busy stays high from INIT through CLEAR.
// Results cannot be stalled: each strobes for exactly one cycle.
// Reset clears the sequencer, the fill count and the overflow flag.
module stable_sort_rank_assign #(
    parameter int MAX_ITEMS = ssra_pkg::MAX_ITEMS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ssra_pkg::item_t   item,
    output logic              busy,
    output logic              strobe,
    output ssra_pkg::result_t result
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // ------------------------------------------------------------------
    // Sequencer: step counter addressing the control store
    // ------------------------------------------------------------------
    logic [ssra_pkg::STEP_W-1:0] step_reg, step_next;
    ssra_pkg::ctl_t              ctl;

    // Set bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // Ranking datapath
    logic [AW-1:0]                        i_reg, i_next;
    logic [AW-1:0]                        j_reg, j_next;
    logic [AW-1:0]                        rank_reg, rank_next;
    logic signed [ssra_pkg::VALUE_W-1:0]  vi_reg, vi_next;

    // Result register
    ssra_pkg::result_t result_reg, result_next;
    logic              strobe_reg, strobe_next;

    // RAM interface
    logic                                 ram_we;
    logic [AW-1:0]                        ram_waddr;
    logic [AW-1:0]                        ram_raddr;
    logic [ssra_pkg::VALUE_W-1:0]         ram_rdata;
    logic signed [ssra_pkg::VALUE_W-1:0]  vj;

    logic          accept;
    logic          close_set;
    logic          has_room;
    logic [AW-1:0] last_idx;
    logic          j_last;
    logic          i_last;
    logic          hit;
    logic          cond_true;

    assign ctl       = ssra_pkg::ucode(step_reg);
    assign busy      = ctl.busy;
    assign accept    = start && !ctl.busy;
    assign close_set = accept && item.last_item;
    assign has_room  = (count_reg < CW'(MAX_ITEMS));

    // A closed set always holds at least one element
    assign last_idx = AW'(count_reg - CW'(1));
    assign j_last   = (j_reg == last_idx);
    assign i_last   = (i_reg == last_idx);

    // Store the transaction while there is room
    assign ram_we    = accept && has_room;
    assign ram_waddr = count_reg[AW-1:0];

    always_comb
    begin
        unique case (ctl.addr_sel)
            ssra_pkg::ADDR_I:      ram_raddr = i_reg;
            ssra_pkg::ADDR_J:      ram_raddr = j_reg;
            ssra_pkg::ADDR_J_NEXT: ram_raddr = j_reg + AW'(1);
            default:               ram_raddr = i_reg;
        endcase
    end

    ssra_ram #(
        .WIDTH (ssra_pkg::VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign vj = $signed(ram_rdata);

    // Element j ranks ahead of i if smaller, or equal and loaded earlier
    assign hit = (vj < vi_reg) || ((vj == vi_reg) && (j_reg < i_reg));

    always_comb
    begin
        unique case (ctl.cond)
            ssra_pkg::COND_NEVER:    cond_true = 1'b0;
            ssra_pkg::COND_ALWAYS:   cond_true = 1'b1;
            ssra_pkg::COND_NO_CLOSE: cond_true = !close_set;
            ssra_pkg::COND_J_MORE:   cond_true = !j_last;
            ssra_pkg::COND_I_MORE:   cond_true = !i_last;
            default:                 cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next   = cond_true ? ctl.target : step_reg + ssra_pkg::STEP_W'(1);
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        rank_next   = rank_reg;
        vi_next     = vi_reg;
        result_next = result_reg;
        strobe_next = 1'b0;

        // Load: append or drop and flag
        if (accept)
        begin
            if (has_room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (ctl.clr_i)
        begin
            i_next = '0;
        end
        if (ctl.clr_j)
        begin
            j_next    = '0;
            rank_next = '0;
        end
        if (ctl.ld_vi)
        begin
            vi_next = $signed(ram_rdata);
        end
        if (ctl.cmp)
        begin
            j_next = j_reg + AW'(1);
            if (hit)
            begin
                rank_next = rank_reg + AW'(1);
            end
        end
        if (ctl.emit)
        begin
            strobe_next             = 1'b1;
            result_next.position    = ssra_pkg::POS_W'(i_reg);
            result_next.rank        = ssra_pkg::POS_W'(rank_reg);
            result_next.item_count  = ssra_pkg::COUNT_W'(count_reg);
            result_next.overflowed  = ovf_reg;
            result_next.last_result = i_last;
        end
        if (ctl.inc_i)
        begin
            i_next = i_reg + AW'(1);
        end
        // Drop the set, ready for the next one
        if (ctl.clr_set)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ssra_pkg::ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        rank_reg   <= rank_next;
        vi_reg     <= vi_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
